// ===== rtl/core/jvm_int_stack_executor_assert.svh =====
// Assertion macros used by the checker file jse_checker.sv.
`ifndef JVM_INT_STACK_EXECUTOR_ASSERT_SVH
`define JVM_INT_STACK_EXECUTOR_ASSERT_SVH

// Checks an implication on every clock edge while out of reset.
`define JSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define JSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/jse_pkg.sv =====
`default_nettype none
package jse_pkg;
  localparam int unsigned StackDepth = 32;
  localparam int unsigned LocalCount = 256;
  localparam int unsigned SpW = $clog2(StackDepth + 1);
  localparam int unsigned SaW = $clog2(StackDepth);
  localparam int unsigned LaW = $clog2(LocalCount);

  localparam logic [7:0] OpIconstM1 = 8'h02;
  localparam logic [7:0] OpIconst0 = 8'h03;
  localparam logic [7:0] OpIconst1 = 8'h04;
  localparam logic [7:0] OpIconst2 = 8'h05;
  localparam logic [7:0] OpIconst3 = 8'h06;
  localparam logic [7:0] OpIconst5 = 8'h08;
  localparam logic [7:0] OpBipush = 8'h10;
  localparam logic [7:0] OpSipush = 8'h11;
  localparam logic [7:0] OpLdc = 8'h12;
  localparam logic [7:0] OpLdc2W = 8'h14;
  localparam logic [7:0] OpIload = 8'h15;
  localparam logic [7:0] OpIload1 = 8'h1B;
  localparam logic [7:0] OpIload3 = 8'h1D;
  localparam logic [7:0] OpAload0 = 8'h2A;
  localparam logic [7:0] OpIstore = 8'h36;
  localparam logic [7:0] OpIstore1 = 8'h3C;
  localparam logic [7:0] OpIstore2 = 8'h3D;
  localparam logic [7:0] OpIstore3 = 8'h3E;
  localparam logic [7:0] OpDup = 8'h59;
  localparam logic [7:0] OpIadd = 8'h60;
  localparam logic [7:0] OpIsub = 8'h64;
  localparam logic [7:0] OpImul = 8'h68;
  localparam logic [7:0] OpIdiv = 8'h6C;
  localparam logic [7:0] OpIrem = 8'h70;
  localparam logic [7:0] OpReturn = 8'hB1;
  localparam logic [7:0] OpGetstatic = 8'hB2;
  localparam logic [7:0] OpNew = 8'hBB;

  typedef enum logic [2:0] {
    StOk = 3'd0, StRet = 3'd1, StBad = 3'd2, StUnder = 3'd3, StOver = 3'd4, StDivZero = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ActPush, ActBin, ActStore, ActDup, ActNop, ActRet, ActBad
  } act_e;

  // Controller to datapath.
  typedef struct packed {
    logic    latch;     // capture the input item and decode it
    logic    exec;      // evaluate checks, start the divider if needed
    logic    commit;    // write back and form the result
    logic    clr_step;  // local clearing sweep step
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic    div_busy;
    logic    clr_done;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/jse_if.sv =====
`default_nettype none
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd;
  logic [7:0] operand_hi;
  logic [7:0] operand_lo;
  modport source (output valid, cmd, operand_hi, operand_lo, input ready);
  modport sink (input valid, cmd, operand_hi, operand_lo, output ready);
endinterface

interface jse_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] top_value;
  logic              top_is_ref;
  logic [5:0]        stack_depth;
  logic [1:0]        insn_length;
  logic [2:0]        status;
  modport source (output valid, top_value, top_is_ref, stack_depth, insn_length, status,
                  input ready);
  modport sink (input valid, top_value, top_is_ref, stack_depth, insn_length, status,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/jse_ram.sv =====
`default_nettype none
module jse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/jse_div.sv =====
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle.
module jse_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output      logic        busy_o,
  output      logic [31:0] quot_o,
  output      logic [31:0] rem_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] q_q, q_d, r_q, r_d, d_q, d_d;
  logic [32:0] trial;

  assign trial = {r_q, q_q[31]} - {1'b0, d_q};

  always_comb begin
    cnt_d = cnt_q;
    q_d = q_q;
    r_d = r_q;
    d_d = d_q;
    if (start_i) begin
      cnt_d = 6'd32;
      q_d = dividend_i;
      r_d = '0;
      d_d = divisor_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (trial[32]) begin
        r_d = {r_q[30:0], q_q[31]};
        q_d = {q_q[30:0], 1'b0};
      end else begin
        r_d = trial[31:0];
        q_d = {q_q[30:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = q_q;
  assign rem_o = r_q;
endmodule
`default_nettype wire

// ===== rtl/core/jse_datapath.sv =====
`default_nettype none
module jse_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire jse_pkg::ctrl_t ctrl_i,
  output      jse_pkg::stat_t stat_o,
  input  wire logic [7:0]     cmd_i,
  input  wire logic [7:0]     operand_hi_i,
  input  wire logic [7:0]     operand_lo_i,
  output      logic [31:0]    top_value_o,
  output      logic           top_is_ref_o,
  output      logic [5:0]     stack_depth_o,
  output      logic [1:0]     insn_length_o,
  output      logic [2:0]     status_o
);
  localparam int unsigned SpW = jse_pkg::SpW;
  localparam int unsigned SaW = jse_pkg::SaW;
  localparam int unsigned LaW = jse_pkg::LaW;

  // Decoded instruction.
  logic [7:0]       op_q;
  jse_pkg::act_e    act_q, act_d;
  logic [1:0]       len_q, len_d;
  logic [31:0]      pv_q, pv_d;
  logic             pt_q, pt_d;
  logic             use_local_q, use_local_d;
  logic [LaW-1:0]   lidx_q, lidx_d;

  logic [SpW-1:0]   sp_q, sp_d;
  logic             halted_q;
  logic [31:0]      top_q;
  logic             top_ref_q;
  logic [1:0]       len_out_q;
  jse_pkg::status_e st_q;

  // Local clearing sweep.
  logic [LaW:0]     clr_q;

  // Stack memories: port A reads top-1, port B reads top-2.
  logic             s_we;
  logic [SaW-1:0]   s_waddr, s_ra, s_rb;
  logic [32:0]      s_wdata, s_rda, s_rdb;
  logic             l_we;
  logic [LaW-1:0]   l_waddr;
  logic [31:0]      l_wdata, l_rd;

  logic             div_start;
  logic             div_busy;
  logic [31:0]      quot, rem;
  logic [31:0]      a_v, b_v, ma, mb;
  logic             na, nb;
  logic [31:0]      arith_q;
  logic             pend_div_q;
  jse_pkg::status_e chk;

  jse_ram #(.Width(33), .Depth(jse_pkg::StackDepth)) u_stk_a (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata), .raddr_i(s_ra),
    .rdata_o(s_rda));
  jse_ram #(.Width(33), .Depth(jse_pkg::StackDepth)) u_stk_b (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata), .raddr_i(s_rb),
    .rdata_o(s_rdb));
  jse_ram #(.Width(32), .Depth(jse_pkg::LocalCount)) u_locals (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata), .raddr_i(lidx_q),
    .rdata_o(l_rd));

  assign s_ra = SaW'(sp_q - SpW'(1));
  assign s_rb = SaW'(sp_q - SpW'(2));

  // Decode.
  always_comb begin
    act_d = jse_pkg::ActBad;
    len_d = 2'd0;
    pv_d = '0;
    pt_d = 1'b0;
    use_local_d = 1'b0;
    lidx_d = '0;
    if (cmd_i == jse_pkg::OpAload0) begin
      act_d = jse_pkg::ActPush; len_d = 2'd1;
    end else if (cmd_i >= jse_pkg::OpIconst0 && cmd_i <= jse_pkg::OpIconst5) begin
      act_d = jse_pkg::ActPush; len_d = 2'd1; pv_d = {24'd0, cmd_i - jse_pkg::OpIconst0};
    end else if (cmd_i == jse_pkg::OpBipush) begin
      act_d = jse_pkg::ActPush; len_d = 2'd2; pv_d = {{24{operand_hi_i[7]}}, operand_hi_i};
    end else if (cmd_i == jse_pkg::OpSipush) begin
      act_d = jse_pkg::ActPush; len_d = 2'd3;
      pv_d = {{16{operand_hi_i[7]}}, operand_hi_i, operand_lo_i};
    end else if (cmd_i == jse_pkg::OpLdc) begin
      act_d = jse_pkg::ActPush; len_d = 2'd2; pv_d = {24'd0, operand_hi_i}; pt_d = 1'b1;
    end else if (cmd_i == jse_pkg::OpLdc2W || cmd_i == jse_pkg::OpGetstatic) begin
      act_d = jse_pkg::ActPush; len_d = 2'd3; pv_d = {16'd0, operand_hi_i, operand_lo_i};
      pt_d = 1'b1;
    end else if (cmd_i == jse_pkg::OpIload) begin
      act_d = jse_pkg::ActPush; len_d = 2'd2; use_local_d = 1'b1;
      lidx_d = LaW'(operand_hi_i);
    end else if (cmd_i >= jse_pkg::OpIload1 && cmd_i <= jse_pkg::OpIload3) begin
      act_d = jse_pkg::ActPush; len_d = 2'd1; use_local_d = 1'b1;
      lidx_d = LaW'(cmd_i - (jse_pkg::OpIload1 - 8'd1));
    end else if (cmd_i == jse_pkg::OpIstore) begin
      act_d = jse_pkg::ActStore; len_d = 2'd2; lidx_d = LaW'(operand_hi_i);
    end else if (cmd_i >= jse_pkg::OpIstore1 && cmd_i <= jse_pkg::OpIstore3) begin
      act_d = jse_pkg::ActStore; len_d = 2'd1;
      lidx_d = LaW'(cmd_i - (jse_pkg::OpIstore1 - 8'd1));
    end else if (cmd_i == jse_pkg::OpDup) begin
      act_d = jse_pkg::ActDup; len_d = 2'd1;
    end else if (cmd_i == jse_pkg::OpIadd || cmd_i == jse_pkg::OpIsub ||
                 cmd_i == jse_pkg::OpImul || cmd_i == jse_pkg::OpIdiv ||
                 cmd_i == jse_pkg::OpIrem) begin
      act_d = jse_pkg::ActBin; len_d = 2'd1;
    end else if (cmd_i == jse_pkg::OpNew) begin
      act_d = jse_pkg::ActNop; len_d = 2'd3;
    end else if (cmd_i == jse_pkg::OpReturn) begin
      act_d = jse_pkg::ActRet; len_d = 2'd1;
    end
  end

  assign a_v = s_rdb[31:0];
  assign b_v = s_rda[31:0];
  assign na = a_v[31];
  assign nb = b_v[31];
  assign ma = na ? (32'd0 - a_v) : a_v;
  assign mb = nb ? (32'd0 - b_v) : b_v;

  // Error checks against the current depth, plus divide by zero, return and unknown opcodes.
  always_comb begin
    chk = jse_pkg::StOk;
    unique case (act_q)
      jse_pkg::ActPush:  if (sp_q >= SpW'(jse_pkg::StackDepth)) chk = jse_pkg::StOver;
      jse_pkg::ActStore: if (sp_q < SpW'(1)) chk = jse_pkg::StUnder;
      jse_pkg::ActDup: begin
        if (sp_q < SpW'(1)) chk = jse_pkg::StUnder;
        else if (sp_q >= SpW'(jse_pkg::StackDepth)) chk = jse_pkg::StOver;
      end
      jse_pkg::ActBin: begin
        if (sp_q < SpW'(2)) chk = jse_pkg::StUnder;
        else if ((op_q == jse_pkg::OpIdiv || op_q == jse_pkg::OpIrem) && b_v == 32'd0)
          chk = jse_pkg::StDivZero;
      end
      jse_pkg::ActNop:   chk = jse_pkg::StOk;
      jse_pkg::ActRet:   chk = jse_pkg::StRet;
      default:           chk = jse_pkg::StBad;
    endcase
  end

  assign div_start = ctrl_i.exec && !halted_q && act_q == jse_pkg::ActBin &&
                     chk == jse_pkg::StOk &&
                     (op_q == jse_pkg::OpIdiv || op_q == jse_pkg::OpIrem);

  jse_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(ma), .divisor_i(mb),
    .busy_o(div_busy), .quot_o(quot), .rem_o(rem));

  // Writes happen at commit; the sweep owns the local port after reset.
  always_comb begin
    s_we = 1'b0;
    s_waddr = SaW'(sp_q);
    s_wdata = {pt_q, pv_q};
    l_we = 1'b0;
    l_waddr = lidx_q;
    l_wdata = b_v;
    sp_d = sp_q;
    if (ctrl_i.clr_step) begin
      l_we = 1'b1;
      l_waddr = clr_q[LaW-1:0];
      l_wdata = '0;
    end else if (ctrl_i.commit && !halted_q && st_q == jse_pkg::StOk) begin
      unique case (act_q)
        jse_pkg::ActPush: begin
          s_we = 1'b1;
          s_wdata = use_local_q ? {1'b0, l_rd} : {pt_q, pv_q};
          sp_d = sp_q + SpW'(1);
        end
        jse_pkg::ActDup: begin
          s_we = 1'b1; s_wdata = s_rda; sp_d = sp_q + SpW'(1);
        end
        jse_pkg::ActStore: begin
          l_we = 1'b1; sp_d = sp_q - SpW'(1);
        end
        jse_pkg::ActBin: begin
          s_we = 1'b1; s_waddr = SaW'(sp_q - SpW'(2));
          s_wdata = {1'b0, pend_div_q ?
                     (op_q == jse_pkg::OpIdiv ? ((na ^ nb) ? 32'd0 - quot : quot)
                                              : (na ? 32'd0 - rem : rem)) : arith_q};
          sp_d = sp_q - SpW'(1);
        end
        default: sp_d = sp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      halted_q <= 1'b0;
      clr_q <= '0;
      pend_div_q <= 1'b0;
      st_q <= jse_pkg::StOk;
    end else begin
      sp_q <= sp_d;
      if (ctrl_i.clr_step) clr_q <= clr_q + (LaW + 1)'(1);
      if (ctrl_i.exec) begin
        pend_div_q <= div_start;
        st_q <= halted_q ? jse_pkg::StRet : chk;
      end
      if (ctrl_i.commit && !halted_q && act_q == jse_pkg::ActRet) halted_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      op_q <= cmd_i;
      act_q <= act_d;
      len_q <= len_d;
      pv_q <= pv_d;
      pt_q <= pt_d;
      use_local_q <= use_local_d;
      lidx_q <= lidx_d;
    end
    if (ctrl_i.exec) begin
      unique case (op_q)
        jse_pkg::OpIadd: arith_q <= a_v + b_v;
        jse_pkg::OpIsub: arith_q <= a_v - b_v;
        default:         arith_q <= 32'(a_v * b_v);
      endcase
    end
  end

  // The result shows the new top, read back from memory after the commit.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) len_out_q <= halted_q ? 2'd0 : len_q;
  end
  always_comb begin
    top_q = (sp_q != '0) ? s_rda[31:0] : 32'd0;
    top_ref_q = (sp_q != '0) ? s_rda[32] : 1'b0;
  end

  assign top_value_o = top_q;
  assign top_is_ref_o = top_ref_q;
  assign stack_depth_o = 6'(sp_q);
  assign insn_length_o = len_out_q;
  assign status_o = st_q;
  assign stat_o.div_busy = div_busy;
  assign stat_o.clr_done = clr_q[LaW];
endmodule
`default_nettype wire

// ===== rtl/core/jse_ctrl.sv =====
`default_nettype none
module jse_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      jse_pkg::ctrl_t ctrl_o,
  input  wire jse_pkg::stat_t stat_i
);
  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle = 3'd1;
  localparam logic [2:0] SRead = 3'd2;
  localparam logic [2:0] SExec = 3'd3;
  localparam logic [2:0] SDiv = 3'd4;
  localparam logic [2:0] SCommit = 3'd5;
  localparam logic [2:0] SSettle = 3'd6;
  localparam logic [2:0] SOut = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      SClear: begin
        ctrl_o.clr_step = !stat_i.clr_done;
        if (stat_i.clr_done) state_d = SIdle;
      end
      SIdle: begin
        in_ready_o = 1'b1;
        ctrl_o.latch = in_valid_i;
        if (in_valid_i) state_d = SRead;
      end
      SRead: begin
        state_d = SExec;
      end
      SExec: begin
        ctrl_o.exec = 1'b1;
        state_d = SDiv;
      end
      SDiv: if (!stat_i.div_busy) state_d = SCommit;
      SCommit: begin
        ctrl_o.commit = 1'b1;
        state_d = SSettle;
      end
      SSettle: state_d = SOut;
      SOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SClear;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ===== rtl/core/jvm_int_stack_executor.sv =====
// Sequencing: after an input transfer the controller passes through read, execute,
// divide-wait, commit and settle states before the result is valid; idiv and irem
// wait for the one-bit-per-cycle divider. One bytecode is handled at a time, since
// the stack memory reads are registered and the write-back ends before the next item.
// Reset: asynchronous active low; empties the stack, clears halt, then a sweep
// zeroes all 256 local variables while no input is taken.
`default_nettype none
module jvm_int_stack_executor (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jse_in_if.sink    in_i,
  jse_out_if.source out_o
);
  jse_pkg::ctrl_t ctrl;
  jse_pkg::stat_t stat;
  logic [31:0]    top;

  jse_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready), .ctrl_o(ctrl), .stat_i(stat));

  jse_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i(in_i.cmd), .operand_hi_i(in_i.operand_hi), .operand_lo_i(in_i.operand_lo),
    .top_value_o(top), .top_is_ref_o(out_o.top_is_ref), .stack_depth_o(out_o.stack_depth),
    .insn_length_o(out_o.insn_length), .status_o(out_o.status));

  assign out_o.top_value = top;
endmodule
`default_nettype wire

// ===== rtl/core/jse_checker.sv =====
`default_nettype none
`include "jvm_int_stack_executor_assert.svh"
module jse_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] depth,
  input wire logic [2:0] status
);
  `JSE_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid, !in_ready, "in ready while result held")
  `JSE_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid, "result dropped")
  `JSE_ASSERT_IMP(a_depth, clk_i, rst_ni, out_valid, depth <= 6'd32, "depth out of range")
  `JSE_ASSERT_IMP(a_status, clk_i, rst_ni, out_valid, status <= 3'd5, "bad status code")
endmodule

bind jvm_int_stack_executor jse_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_i.valid), .in_ready(in_i.ready), .out_valid(out_o.valid),
  .out_ready(out_o.ready), .depth(out_o.stack_depth), .status(out_o.status));
`default_nettype wire
